### design/salu_pkg.sv
// Shared types and opcode codes for the shifter ALU.
`default_nettype none
package salu_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned AmtW  = 5;
    localparam int unsigned OpW   = 5;

    typedef enum logic [OpW-1:0] {
        OP_LSL = 5'd0,
        OP_LSR = 5'd1,
        OP_ASR = 5'd2,
        OP_ROR = 5'd3,
        OP_ADD = 5'd4,
        OP_SUB = 5'd5,
        OP_ADC = 5'd6,
        OP_SBC = 5'd7,
        OP_MUL = 5'd8,
        OP_AND = 5'd9,
        OP_ORR = 5'd10,
        OP_EOR = 5'd11,
        OP_BIC = 5'd12,
        OP_NEG = 5'd13,
        OP_MOV = 5'd14,
        OP_MVN = 5'd15,
        OP_CMP = 5'd16,
        OP_CMN = 5'd17,
        OP_TST = 5'd18
    } t_op;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             carry;
    } t_shift_res;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             writes;
        t_flags           flags;
    } t_exec_res;

endpackage
`default_nettype wire

### design/salu_shift.sv
// Barrel shifter with shifter carry out and the amount-zero special cases.
`default_nettype none
module salu_shift (
    input  var salu_pkg::t_op                  i_op,
    input  wire logic [salu_pkg::DataW-1:0]    i_value,
    input  wire logic [salu_pkg::AmtW-1:0]     i_amount,
    input  wire logic                          i_carry,
    output var salu_pkg::t_shift_res           o_res
);

    logic [salu_pkg::DataW:0]     w_lsl;
    logic [salu_pkg::DataW:0]     w_lsr;
    logic [salu_pkg::DataW:0]     w_asr;
    logic [2*salu_pkg::DataW-1:0] w_ror;
    logic                         w_msb;

    assign w_msb = i_value[salu_pkg::DataW-1];
    // extra bit on the outgoing side catches the last bit shifted out
    assign w_lsl = {1'b0, i_value} << i_amount;
    assign w_lsr = {i_value, 1'b0} >> i_amount;
    assign w_asr = $unsigned($signed({i_value, 1'b0}) >>> i_amount);
    assign w_ror = {i_value, i_value} >> i_amount;

    always_comb begin
        o_res = '0;
        if (i_amount == '0) begin
            case (i_op)
                salu_pkg::OP_LSL: begin
                    o_res.value = i_value;
                    o_res.carry = i_carry;
                end
                salu_pkg::OP_LSR: begin
                    o_res.value = '0;
                    o_res.carry = w_msb;
                end
                salu_pkg::OP_ASR: begin
                    o_res.value = {salu_pkg::DataW{w_msb}};
                    o_res.carry = w_msb;
                end
                default: begin
                    // RRX
                    o_res.value = {i_carry, i_value[salu_pkg::DataW-1:1]};
                    o_res.carry = i_value[0];
                end
            endcase
        end else begin
            case (i_op)
                salu_pkg::OP_LSL: begin
                    o_res.value = w_lsl[salu_pkg::DataW-1:0];
                    o_res.carry = w_lsl[salu_pkg::DataW];
                end
                salu_pkg::OP_LSR: begin
                    o_res.value = w_lsr[salu_pkg::DataW:1];
                    o_res.carry = w_lsr[0];
                end
                salu_pkg::OP_ASR: begin
                    o_res.value = w_asr[salu_pkg::DataW:1];
                    o_res.carry = w_asr[0];
                end
                default: begin
                    o_res.value = w_ror[salu_pkg::DataW-1:0];
                    o_res.carry = w_ror[salu_pkg::DataW-1];
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### design/salu_exec.sv
// Execute logic: adder, multiplier, logic unit, shifter and flag selection.
`default_nettype none
module salu_exec (
    input  var salu_pkg::t_op                  i_op,
    input  wire logic [salu_pkg::DataW-1:0]    i_a,
    input  wire logic [salu_pkg::DataW-1:0]    i_b,
    input  wire logic [salu_pkg::AmtW-1:0]     i_amount,
    input  wire logic                          i_set_flags,
    input  var salu_pkg::t_flags               i_flags,
    output var salu_pkg::t_exec_res            o_res
);

    localparam int unsigned W = salu_pkg::DataW;

    salu_pkg::t_shift_res w_shift;
    logic [W-1:0]         w_add_a;
    logic [W-1:0]         w_add_b;
    logic                 w_cin;
    logic [W:0]           w_sum;
    logic                 w_ovf;
    logic [W-1:0]         w_prod;
    logic [W-1:0]         w_logic;
    salu_pkg::t_flags     w_nf;
    logic                 w_upd;

    salu_shift u_shift (
        .i_op     (i_op),
        .i_value  (i_a),
        .i_amount (i_amount),
        .i_carry  (i_flags.c),
        .o_res    (w_shift)
    );

    // adder operand setup
    always_comb begin
        w_add_a = i_a;
        w_add_b = i_b;
        w_cin   = 1'b0;
        case (i_op)
            salu_pkg::OP_SUB, salu_pkg::OP_CMP: begin
                w_add_b = ~i_b;
                w_cin   = 1'b1;
            end
            salu_pkg::OP_ADC: begin
                w_cin = i_flags.c;
            end
            salu_pkg::OP_SBC: begin
                w_add_b = ~i_b;
                w_cin   = i_flags.c;
            end
            salu_pkg::OP_NEG: begin
                w_add_a = '0;
                w_add_b = ~i_b;
                w_cin   = 1'b1;
            end
            default: begin
                w_cin = 1'b0;
            end
        endcase
    end

    assign w_sum  = {1'b0, w_add_a} + {1'b0, w_add_b} + {{W{1'b0}}, w_cin};
    assign w_ovf  = ~(w_add_a[W-1] ^ w_add_b[W-1]) & (w_add_a[W-1] ^ w_sum[W-1]);
    assign w_prod = i_a * i_b;

    always_comb begin
        case (i_op)
            salu_pkg::OP_MUL: w_logic = w_prod;
            salu_pkg::OP_ORR: w_logic = i_a | i_b;
            salu_pkg::OP_EOR: w_logic = i_a ^ i_b;
            salu_pkg::OP_BIC: w_logic = i_a & ~i_b;
            salu_pkg::OP_MOV: w_logic = i_b;
            salu_pkg::OP_MVN: w_logic = ~i_b;
            default:          w_logic = i_a & i_b;
        endcase
    end

    always_comb begin
        o_res.result = '0;
        o_res.writes = 1'b0;
        w_nf         = i_flags;
        w_upd        = 1'b0;
        case (i_op)
            salu_pkg::OP_LSL, salu_pkg::OP_LSR, salu_pkg::OP_ASR, salu_pkg::OP_ROR: begin
                o_res.result = w_shift.value;
                o_res.writes = 1'b1;
                w_nf = '{n: w_shift.value[W-1], z: (w_shift.value == '0),
                         c: w_shift.carry, v: i_flags.v};
                w_upd = i_set_flags;
            end
            salu_pkg::OP_ADD, salu_pkg::OP_SUB, salu_pkg::OP_ADC,
            salu_pkg::OP_SBC, salu_pkg::OP_NEG: begin
                o_res.result = w_sum[W-1:0];
                o_res.writes = 1'b1;
                w_nf = '{n: w_sum[W-1], z: (w_sum[W-1:0] == '0), c: w_sum[W], v: w_ovf};
                w_upd = i_set_flags;
            end
            salu_pkg::OP_CMP, salu_pkg::OP_CMN: begin
                w_nf = '{n: w_sum[W-1], z: (w_sum[W-1:0] == '0), c: w_sum[W], v: w_ovf};
                w_upd = 1'b1;
            end
            salu_pkg::OP_MUL, salu_pkg::OP_AND, salu_pkg::OP_ORR, salu_pkg::OP_EOR,
            salu_pkg::OP_BIC, salu_pkg::OP_MOV, salu_pkg::OP_MVN: begin
                o_res.result = w_logic;
                o_res.writes = 1'b1;
                w_nf = '{n: w_logic[W-1], z: (w_logic == '0), c: i_flags.c, v: i_flags.v};
                w_upd = i_set_flags;
            end
            salu_pkg::OP_TST: begin
                w_nf = '{n: w_logic[W-1], z: (w_logic == '0), c: i_flags.c, v: i_flags.v};
                w_upd = 1'b1;
            end
            default: begin
                // unassigned opcodes: no result, flags untouched
                w_upd = 1'b0;
            end
        endcase
        o_res.flags = w_upd ? w_nf : i_flags;
    end

endmodule
`default_nettype wire

### design/shifter_alu_with_flags.sv
// Top level: input register, execute logic, NZCV register and output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_ready  | opcode, operand_a, operand_b, shift_amount,
//          |           |                    | set_flags
//  output  | out       | o_valid / i_ready  | result, writes_result, flag_n/z/c/v
//
// One word per cycle sustained while i_ready is high; o_valid rises as the output
// register takes the word from the input register. The path from the input register
// through the adder or the 32x32 multiplier into the output register sets the cycle time.
// Reset clears both valid bits and the flags to zero.
// A stalled output word holds; the input register still takes one more word.
`default_nettype none
module shifter_alu_with_flags (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [salu_pkg::OpW-1:0]      i_opcode,
    input  wire logic [salu_pkg::DataW-1:0]    i_operand_a,
    input  wire logic [salu_pkg::DataW-1:0]    i_operand_b,
    input  wire logic [salu_pkg::AmtW-1:0]     i_shift_amount,
    input  wire logic                          i_set_flags,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [salu_pkg::DataW-1:0]         o_result,
    output logic                               o_writes_result,
    output logic                               o_flag_n,
    output logic                               o_flag_z,
    output logic                               o_flag_c,
    output logic                               o_flag_v
);

    logic                          r_s1_valid;
    salu_pkg::t_op                 r_op;
    logic [salu_pkg::DataW-1:0]    r_a;
    logic [salu_pkg::DataW-1:0]    r_b;
    logic [salu_pkg::AmtW-1:0]     r_amount;
    logic                          r_set_flags;
    salu_pkg::t_flags              r_flags;
    logic                          r_out_valid;
    salu_pkg::t_exec_res           r_out;
    salu_pkg::t_exec_res           n_out;
    logic                          w_in_fire;
    logic                          w_s1_fire;

    assign w_s1_fire = r_s1_valid & (~r_out_valid | i_ready);
    assign o_ready   = ~r_s1_valid | w_s1_fire;
    assign w_in_fire = i_valid & o_ready;

    salu_exec u_exec (
        .i_op        (r_op),
        .i_a         (r_a),
        .i_b         (r_b),
        .i_amount    (r_amount),
        .i_set_flags (r_set_flags),
        .i_flags     (r_flags),
        .o_res       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_out.flags;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op        <= salu_pkg::t_op'(i_opcode);
            r_a         <= i_operand_a;
            r_b         <= i_operand_b;
            r_amount    <= i_shift_amount;
            r_set_flags <= i_set_flags;
        end
        if (w_s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result        = r_out.result;
    assign o_writes_result = r_out.writes;
    assign o_flag_n        = r_out.flags.n;
    assign o_flag_z        = r_out.flags.z;
    assign o_flag_c        = r_out.flags.c;
    assign o_flag_v        = r_out.flags.v;

`ifndef NO_ASSERTIONS
    a_out_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.flags == r_flags)
        else $error("output word flags differ from flag register");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_fire |=> $stable(r_flags))
        else $error("flags changed with no word executed");

    a_compare_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire && (r_op == salu_pkg::OP_CMP || r_op == salu_pkg::OP_CMN ||
                      r_op == salu_pkg::OP_TST) |=> !o_writes_result)
        else $error("compare produced a register write");

    a_empty_takes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_ready)
        else $error("empty input register refused a word");

    a_out_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out))
        else $error("stalled output word lost or changed");
`endif

endmodule
`default_nettype wire
